@@ rtl/pew_pkg.sv @@
package pew_pkg;

  localparam int POSITION_FRACTION_BITS = 16;
  localparam int ANGLE_FRACTION_BITS    = 14;

  localparam int POS_W = 32;
  localparam int QUAT_W = 16;
  localparam int ATT_W = 15;
  localparam int AXES_W = 6;

  // limit resets are 0.2 in the respective fixed-point format
  localparam logic [POS_W-1:0] POS_LIMIT_RESET =
    POS_W'(((64'd2 << POSITION_FRACTION_BITS) + 64'd5) / 64'd10);
  localparam logic [ATT_W-1:0] ATT_LIMIT_RESET =
    ATT_W'(((64'd2 << ANGLE_FRACTION_BITS) + 64'd5) / 64'd10);
  localparam logic [ATT_W-1:0] ATT_MAX = '1;

  localparam logic signed [QUAT_W-1:0] QUAT_ONE = QUAT_W'(1 << ANGLE_FRACTION_BITS);

  // item kinds
  localparam logic KIND_SETPOINT = 1'b0;
  localparam logic KIND_POSE     = 1'b1;

  // register indexes
  localparam logic REG_POS_LIMIT = 1'b0;
  localparam logic REG_ATT_LIMIT = 1'b1;

  localparam int ACC_W = 68;

  // sequencer states
  typedef enum logic [4:0] {
    IDLE = 5'b00001,
    CALC = 5'b00010,
    SQP  = 5'b00100,
    SQA  = 5'b01000,
    DONE = 5'b10000
  } state_t;

  // shift right by n with rounding half away from zero
  function automatic logic signed [ACC_W-1:0] rnd_shift(logic signed [ACC_W-1:0] v,
                                                         int n);
    logic [ACC_W-1:0] mag;
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    mag = (mag + (ACC_W'(1) << (n - 1))) >> n;
    return v[ACC_W-1] ? -$signed(mag) : $signed(mag);
  endfunction

endpackage

@@ rtl/pew_if.sv @@
interface pew_in_if;
  logic                                valid;
  logic                                ready;
  logic                                kind;
  logic                                frame_is_inertial;
  logic [pew_pkg::AXES_W-1:0]          ignore_axes;
  logic signed [pew_pkg::POS_W-1:0]    pos_x;
  logic signed [pew_pkg::POS_W-1:0]    pos_y;
  logic signed [pew_pkg::POS_W-1:0]    pos_z;
  logic signed [pew_pkg::QUAT_W-1:0]   quat_w;
  logic signed [pew_pkg::QUAT_W-1:0]   quat_x;
  logic signed [pew_pkg::QUAT_W-1:0]   quat_y;
  logic signed [pew_pkg::QUAT_W-1:0]   quat_z;

  modport source (output valid, kind, frame_is_inertial, ignore_axes, pos_x, pos_y, pos_z,
                  quat_w, quat_x, quat_y, quat_z, input ready);
  modport sink (input valid, kind, frame_is_inertial, ignore_axes, pos_x, pos_y, pos_z,
                quat_w, quat_x, quat_y, quat_z, output ready);
endinterface

interface pew_out_if;
  logic                        valid;
  logic                        ready;
  logic                        shutdown;
  logic [pew_pkg::POS_W-1:0]   pos_err_norm;
  logic [pew_pkg::ATT_W-1:0]   att_err_norm;

  modport source (output valid, shutdown, pos_err_norm, att_err_norm, input ready);
  modport sink (input valid, shutdown, pos_err_norm, att_err_norm, output ready);
endinterface

@@ rtl/pose_error_watchdog.sv @@
// Pose error watchdog. Setpoints (kind 0, inertial frame only) load the target
// pose and axis mask; the first such setpoint and the first pose after it are
// dropped. Each later pose yields one beat: the latched shutdown flag and the
// masked position and attitude error norms. Setpoints and dropped poses are
// taken while idle. An evaluated pose runs the multiply-accumulate steps on
// one shared 33x33 multiplier, then the shared bit-serial square root for
// position and then attitude, then posts the result when the output is free;
// the input is not ready meanwhile. The shutdown flag clears only on reset.
module pose_error_watchdog (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  pew_in_if.sink            pose_in,
  pew_out_if.source         err_out
);

  // step numbers of the multiply-accumulate sequence
  localparam logic [5:0] ST_POS  = 6'd0;
  localparam logic [5:0] ST_DOT  = 6'd3;
  localparam logic [5:0] ST_E0   = 6'd7;
  localparam logic [5:0] ST_E1   = 6'd11;
  localparam logic [5:0] ST_E2   = 6'd15;
  localparam logic [5:0] ST_R    = 6'd19;
  localparam logic [5:0] ST_COL  = 6'd37;
  localparam logic [5:0] ST_SQ   = 6'd46;
  localparam logic [5:0] ST_LIM  = 6'd49;
  localparam logic [5:0] ST_LAST = 6'd50;

  localparam int AW = pew_pkg::ACC_W;
  localparam int MW = 33;

  pew_pkg::state_t state;

  logic [pew_pkg::POS_W-1:0] position_limit;
  logic [pew_pkg::ATT_W-1:0] attitude_limit;

  logic setpoint_seen, pose_seen, fault_latched;
  logic signed [31:0] tp [3];
  logic signed [15:0] tq [4];
  logic [5:0]         axis_en;

  // captured pose
  logic signed [31:0] cp [3];
  logic signed [15:0] cq [4];

  // datapath
  logic [5:0]               step;
  logic signed [AW-1:0]     acc, acc_next, acc_base, prod_ext;
  logic signed [MW-1:0]     mul_a, mul_b;
  logic signed [2*MW-1:0]   prod;
  logic                     mul_sub, mul_clr;
  logic [65:0]              psum;
  logic [63:0]              plim2;
  logic [31:0]              asum;
  logic [29:0]              alim2;
  logic                     flip, asat;
  logic signed [17:0]       ev [3];
  logic signed [31:0]       rm [9];
  logic [15:0]              am [3];
  logic signed [AW-1:0]     a_rnd, a_mag, e_src, e_rnd;
  logic [31:0]              perr;

  // square root unit
  logic [63:0] sq_v, sq_r, sq_bit, sq_sum, sq_v_next, sq_r_next;
  logic        sq_ge;
  logic [4:0]  sq_cnt;

  logic signed [MW-1:0] d [3];

  // output
  logic        pover, aover, asat_f;
  logic        out_valid;
  logic        out_shutdown;
  logic [31:0] out_perr;
  logic [14:0] out_aerr;

  // config port
  assign pready = 1'b1;
  always_comb begin
    unique case (paddr[2])
      pew_pkg::REG_POS_LIMIT: prdata = position_limit;
      pew_pkg::REG_ATT_LIMIT: prdata = {17'd0, attitude_limit};
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      position_limit <= pew_pkg::POS_LIMIT_RESET;
      attitude_limit <= pew_pkg::ATT_LIMIT_RESET;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        pew_pkg::REG_POS_LIMIT: position_limit <= pwdata;
        pew_pkg::REG_ATT_LIMIT: attitude_limit <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  // position differences, masked
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d[i] = axis_en[i] ? (MW'(tp[i]) - MW'(cp[i])) : '0;
    end
  end

  // operand select for the shared multiplier
  function automatic logic signed [MW-1:0] xq(logic signed [15:0] v);
    return MW'(v);
  endfunction

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    mul_sub = 1'b0;
    mul_clr = 1'b0;
    unique case (step)
      ST_POS:     begin mul_a = d[0]; mul_b = d[0]; mul_clr = 1'b1; end
      ST_POS+1:   begin mul_a = d[1]; mul_b = d[1]; end
      ST_POS+2:   begin mul_a = d[2]; mul_b = d[2]; end
      ST_DOT:     begin mul_a = xq(tq[0]); mul_b = xq(cq[0]); mul_clr = 1'b1; end
      ST_DOT+1:   begin mul_a = xq(tq[1]); mul_b = xq(cq[1]); end
      ST_DOT+2:   begin mul_a = xq(tq[2]); mul_b = xq(cq[2]); end
      ST_DOT+3:   begin mul_a = xq(tq[3]); mul_b = xq(cq[3]); end
      ST_E0:      begin mul_a = xq(cq[0]); mul_b = xq(tq[1]); mul_clr = 1'b1; end
      ST_E0+1:    begin mul_a = xq(tq[0]); mul_b = xq(cq[1]); mul_sub = 1'b1; end
      ST_E0+2:    begin mul_a = xq(tq[2]); mul_b = xq(cq[3]); mul_sub = 1'b1; end
      ST_E0+3:    begin mul_a = xq(tq[3]); mul_b = xq(cq[2]); end
      ST_E1:      begin mul_a = xq(cq[0]); mul_b = xq(tq[2]); mul_clr = 1'b1; end
      ST_E1+1:    begin mul_a = xq(tq[0]); mul_b = xq(cq[2]); mul_sub = 1'b1; end
      ST_E1+2:    begin mul_a = xq(tq[3]); mul_b = xq(cq[1]); mul_sub = 1'b1; end
      ST_E1+3:    begin mul_a = xq(tq[1]); mul_b = xq(cq[3]); end
      ST_E2:      begin mul_a = xq(cq[0]); mul_b = xq(tq[3]); mul_clr = 1'b1; end
      ST_E2+1:    begin mul_a = xq(tq[0]); mul_b = xq(cq[3]); mul_sub = 1'b1; end
      ST_E2+2:    begin mul_a = xq(tq[1]); mul_b = xq(cq[2]); mul_sub = 1'b1; end
      ST_E2+3:    begin mul_a = xq(tq[2]); mul_b = xq(cq[1]); end
      // rotation matrix entries, two products each
      ST_R:       begin mul_a = xq(tq[2]); mul_b = xq(tq[2]); mul_clr = 1'b1; end
      ST_R+1:     begin mul_a = xq(tq[3]); mul_b = xq(tq[3]); end
      ST_R+2:     begin mul_a = xq(tq[1]); mul_b = xq(tq[2]); mul_clr = 1'b1; end
      ST_R+3:     begin mul_a = xq(tq[3]); mul_b = xq(tq[0]); mul_sub = 1'b1; end
      ST_R+4:     begin mul_a = xq(tq[1]); mul_b = xq(tq[3]); mul_clr = 1'b1; end
      ST_R+5:     begin mul_a = xq(tq[2]); mul_b = xq(tq[0]); end
      ST_R+6:     begin mul_a = xq(tq[1]); mul_b = xq(tq[2]); mul_clr = 1'b1; end
      ST_R+7:     begin mul_a = xq(tq[3]); mul_b = xq(tq[0]); end
      ST_R+8:     begin mul_a = xq(tq[1]); mul_b = xq(tq[1]); mul_clr = 1'b1; end
      ST_R+9:     begin mul_a = xq(tq[3]); mul_b = xq(tq[3]); end
      ST_R+10:    begin mul_a = xq(tq[2]); mul_b = xq(tq[3]); mul_clr = 1'b1; end
      ST_R+11:    begin mul_a = xq(tq[1]); mul_b = xq(tq[0]); mul_sub = 1'b1; end
      ST_R+12:    begin mul_a = xq(tq[1]); mul_b = xq(tq[3]); mul_clr = 1'b1; end
      ST_R+13:    begin mul_a = xq(tq[2]); mul_b = xq(tq[0]); mul_sub = 1'b1; end
      ST_R+14:    begin mul_a = xq(tq[2]); mul_b = xq(tq[3]); mul_clr = 1'b1; end
      ST_R+15:    begin mul_a = xq(tq[1]); mul_b = xq(tq[0]); end
      ST_R+16:    begin mul_a = xq(tq[1]); mul_b = xq(tq[1]); mul_clr = 1'b1; end
      ST_R+17:    begin mul_a = xq(tq[2]); mul_b = xq(tq[2]); end
      // transposed rotation, column by column
      ST_COL:     begin mul_a = MW'(rm[0]); mul_b = MW'(ev[0]); mul_clr = 1'b1; end
      ST_COL+1:   begin mul_a = MW'(rm[3]); mul_b = MW'(ev[1]); end
      ST_COL+2:   begin mul_a = MW'(rm[6]); mul_b = MW'(ev[2]); end
      ST_COL+3:   begin mul_a = MW'(rm[1]); mul_b = MW'(ev[0]); mul_clr = 1'b1; end
      ST_COL+4:   begin mul_a = MW'(rm[4]); mul_b = MW'(ev[1]); end
      ST_COL+5:   begin mul_a = MW'(rm[7]); mul_b = MW'(ev[2]); end
      ST_COL+6:   begin mul_a = MW'(rm[2]); mul_b = MW'(ev[0]); mul_clr = 1'b1; end
      ST_COL+7:   begin mul_a = MW'(rm[5]); mul_b = MW'(ev[1]); end
      ST_COL+8:   begin mul_a = MW'(rm[8]); mul_b = MW'(ev[2]); end
      ST_SQ:      begin mul_a = MW'(am[0]); mul_b = MW'(am[0]); mul_clr = 1'b1; end
      ST_SQ+1:    begin mul_a = MW'(am[1]); mul_b = MW'(am[1]); end
      ST_SQ+2:    begin mul_a = MW'(am[2]); mul_b = MW'(am[2]); end
      ST_LIM:     begin
        mul_a = MW'(position_limit); mul_b = MW'(position_limit); mul_clr = 1'b1;
      end
      ST_LIM+1:   begin
        mul_a = MW'(attitude_limit); mul_b = MW'(attitude_limit); mul_clr = 1'b1;
      end
      default: ;
    endcase
  end

  // shared multiply-accumulate
  assign prod     = mul_a * mul_b;
  assign prod_ext = AW'(prod);
  assign acc_base = mul_clr ? '0 : acc;
  assign acc_next = mul_sub ? acc_base - prod_ext : acc_base + prod_ext;

  // rounding works from the registered sum, one step after it is formed
  assign e_src = flip ? -acc : acc;
  assign e_rnd = pew_pkg::rnd_shift(e_src, pew_pkg::ANGLE_FRACTION_BITS);
  assign a_rnd = pew_pkg::rnd_shift(acc, 2 * pew_pkg::ANGLE_FRACTION_BITS);
  assign a_mag = a_rnd[AW-1] ? -a_rnd : a_rnd;

  // square root iteration
  assign sq_sum    = sq_r + sq_bit;
  assign sq_ge     = sq_v >= sq_sum;
  assign sq_v_next = sq_ge ? sq_v - sq_sum : sq_v;
  assign sq_r_next = sq_ge ? (sq_r >> 1) + sq_bit : sq_r >> 1;

  // result checks
  assign asat_f = asat || (sq_r[31:0] > 32'(pew_pkg::ATT_MAX));
  assign pover  = (psum[65:64] != 2'd0) || (psum[63:0] > plim2);
  assign aover  = asat_f || (asum > 32'(alim2));

  assign pose_in.ready = (state == pew_pkg::IDLE);

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pew_pkg::IDLE;
      setpoint_seen <= 1'b0;
      pose_seen     <= 1'b0;
      fault_latched <= 1'b0;
      tp[0] <= '0; tp[1] <= '0; tp[2] <= '0;
      tq[0] <= pew_pkg::QUAT_ONE; tq[1] <= '0; tq[2] <= '0; tq[3] <= '0;
      axis_en   <= '1;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && err_out.ready && state != pew_pkg::DONE) out_valid <= 1'b0;
      unique case (state)
        pew_pkg::IDLE: begin
          if (pose_in.valid) begin
            if (pose_in.kind == pew_pkg::KIND_SETPOINT) begin
              if (pose_in.frame_is_inertial) begin
                if (!setpoint_seen) begin
                  setpoint_seen <= 1'b1;
                end else begin
                  tp[0] <= pose_in.pos_x; tp[1] <= pose_in.pos_y;
                  tp[2] <= pose_in.pos_z;
                  tq[0] <= pose_in.quat_w; tq[1] <= pose_in.quat_x;
                  tq[2] <= pose_in.quat_y; tq[3] <= pose_in.quat_z;
                  axis_en <= ~pose_in.ignore_axes;
                end
              end
            end else if (setpoint_seen) begin
              if (!pose_seen) begin
                pose_seen <= 1'b1;
              end else begin
                step  <= '0;
                state <= pew_pkg::CALC;
              end
            end
          end
        end
        pew_pkg::CALC: begin
          step <= step + 6'd1;
          if (step == ST_LAST) state <= pew_pkg::SQP;
        end
        pew_pkg::SQP: begin
          if (sq_cnt == 5'd31) state <= pew_pkg::SQA;
        end
        pew_pkg::SQA: begin
          if (sq_cnt == 5'd31) state <= pew_pkg::DONE;
        end
        pew_pkg::DONE: begin
          if (!out_valid || err_out.ready) begin
            out_valid <= 1'b1;
            if (pover || aover) fault_latched <= 1'b1;
            state <= pew_pkg::IDLE;
          end
        end
        default: state <= pew_pkg::IDLE;
      endcase
    end
  end

  // payload and datapath registers
  always_ff @(posedge clk) begin
    if (state == pew_pkg::IDLE) begin
      cp[0] <= pose_in.pos_x; cp[1] <= pose_in.pos_y; cp[2] <= pose_in.pos_z;
      cq[0] <= pose_in.quat_w; cq[1] <= pose_in.quat_x;
      cq[2] <= pose_in.quat_y; cq[3] <= pose_in.quat_z;
      asat <= 1'b0;
    end
    if (state == pew_pkg::CALC) begin
      acc <= acc_next;
      case (step)
        ST_POS+2: psum <= acc_next[65:0];
        ST_DOT+3: flip <= acc_next[AW-1];
        ST_E0+4:  ev[0] <= e_rnd[17:0];
        ST_E1+4:  ev[1] <= e_rnd[17:0];
        ST_E2+4:  ev[2] <= e_rnd[17:0];
        ST_SQ+2:  asum <= acc_next[31:0];
        ST_LIM:   plim2 <= acc_next[63:0];
        ST_LIM+1: alim2 <= acc_next[29:0];
        default: ;
      endcase
      // rotation entries: diagonal is one minus twice, others twice
      for (int k = 0; k < 9; k++) begin
        if (step == ST_R + 6'(2 * k + 1)) begin
          if (k == 0 || k == 4 || k == 8) begin
            rm[k] <= (32'sd1 <<< (2 * pew_pkg::ANGLE_FRACTION_BITS)) -
                     32'(acc_next <<< 1);
          end else begin
            rm[k] <= 32'(acc_next <<< 1);
          end
        end
      end
      // rotated attitude component, masked and range checked
      for (int i = 0; i < 3; i++) begin
        if (step == ST_COL + 6'(3 * i + 3)) begin
          if (!axis_en[3 + i]) begin
            am[i] <= '0;
          end else if (a_mag > AW'(pew_pkg::ATT_MAX)) begin
            am[i] <= '0;
            asat  <= 1'b1;
          end else begin
            am[i] <= a_mag[15:0];
          end
        end
      end
      if (step == ST_LAST) begin
        sq_v   <= psum[63:0];
        sq_r   <= '0;
        sq_bit <= 64'd1 << 62;
        sq_cnt <= '0;
      end
    end
    if (state == pew_pkg::SQP || state == pew_pkg::SQA) begin
      sq_cnt <= sq_cnt + 5'd1;
      if (state == pew_pkg::SQP && sq_cnt == 5'd31) begin
        perr   <= (psum[65:64] != 2'd0) ? '1 : sq_r_next[31:0];
        sq_v   <= 64'(asum);
        sq_r   <= '0;
        sq_bit <= 64'd1 << 62;
      end else begin
        sq_v   <= sq_v_next;
        sq_r   <= sq_r_next;
        sq_bit <= sq_bit >> 2;
      end
    end
    if (state == pew_pkg::DONE && (!out_valid || err_out.ready)) begin
      out_shutdown <= fault_latched || pover || aover;
      out_perr     <= perr;
      out_aerr     <= asat_f ? pew_pkg::ATT_MAX : sq_r[14:0];
    end
  end

  assign err_out.valid        = out_valid;
  assign err_out.shutdown     = out_shutdown;
  assign err_out.pos_err_norm = out_perr;
  assign err_out.att_err_norm = out_aerr;

endmodule

@@ bench/pose_error_watchdog_tb.sv @@
`timescale 1ns / 1ps

module pose_error_watchdog_tb;

  typedef struct {
    logic                              kind;
    logic                              frame_is_inertial;
    logic [pew_pkg::AXES_W-1:0]        ignore_axes;
    logic signed [pew_pkg::POS_W-1:0]  pos [3];
    logic signed [pew_pkg::QUAT_W-1:0] quat [4];
  } pose_item_t;

  typedef struct {
    logic                       shutdown;
    logic [pew_pkg::POS_W-1:0]  pos_err_norm;
    logic [pew_pkg::ATT_W-1:0]  att_err_norm;
  } pose_error_t;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 160;
  localparam int LONG_STALL     = 2000;

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  pew_in_if  pose_in ();
  pew_out_if err_out ();

  pose_error_watchdog DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .pose_in(pose_in), .err_out(err_out)
  );

  pose_item_t  pending_items[$];
  pose_error_t expected_errors[$];
  bit          failed;
  bit          calm;
  int          idle_pct;

  // shadow of the block state
  bit                       sp_seen, pose_seen_q, fault_q;
  longint                   tgt_pos [3];
  longint                   tgt_quat [4];
  bit [pew_pkg::AXES_W-1:0] axis_en;
  bit [63:0]                pos_limit, att_limit;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic longint round_half_away(longint v, int n);
    bit [63:0] mag;
    mag = (v < 0) ? -v : v;
    mag = (mag + (64'd1 << (n - 1))) >> n;
    return (v < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic bit [63:0] int_sqrt(bit [63:0] v);
    bit [63:0] r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // state update for one accepted item; returns 1 when a result is due
  function automatic bit watch_pose(pose_item_t it, output pose_error_t res);
    longint    p [3], q [4], e [3], r [3][3];
    longint    dw, dx, dy, dz, scal, acc, a, one;
    bit [63:0] m, sq, psum, asum, perr, aerr;
    bit        psat, asat, pover, aover;
    for (int i = 0; i < 3; i++) p[i] = it.pos[i];
    for (int i = 0; i < 4; i++) q[i] = it.quat[i];
    res = '{1'b0, '0, '0};
    if (it.kind == pew_pkg::KIND_SETPOINT) begin
      if (!it.frame_is_inertial) return 0;
      if (!sp_seen) begin
        sp_seen = 1;
        return 0;
      end
      tgt_pos = p;
      tgt_quat = q;
      axis_en = ~it.ignore_axes;
      return 0;
    end
    if (!sp_seen) return 0;
    if (!pose_seen_q) begin
      pose_seen_q = 1;
      return 0;
    end
    // position norm
    psat = 0;
    psum = 0;
    for (int i = 0; i < 3; i++) begin
      if (!axis_en[i]) continue;
      m = (tgt_pos[i] - p[i] < 0) ? -(tgt_pos[i] - p[i]) : tgt_pos[i] - p[i];
      if (m > 64'hFFFF_FFFF) begin
        psat = 1;
        break;
      end
      sq = m * m;
      if (psum + sq < psum) begin
        psat = 1;
        break;
      end
      psum += sq;
    end
    perr = psat ? 64'hFFFF_FFFF : int_sqrt(psum);
    pover = psat || psum > pos_limit * pos_limit;
    // attitude error vector, sign fixed by the scalar part
    dw = tgt_quat[0]; dx = tgt_quat[1]; dy = tgt_quat[2]; dz = tgt_quat[3];
    scal = dw * q[0] + dx * q[1] + dy * q[2] + dz * q[3];
    e[0] = q[0] * dx - dw * q[1] - (dy * q[3] - dz * q[2]);
    e[1] = q[0] * dy - dw * q[2] - (dz * q[1] - dx * q[3]);
    e[2] = q[0] * dz - dw * q[3] - (dx * q[2] - dy * q[1]);
    for (int i = 0; i < 3; i++) begin
      if (scal < 0) e[i] = -e[i];
      e[i] = round_half_away(e[i], pew_pkg::ANGLE_FRACTION_BITS);
    end
    one = longint'(1) << (2 * pew_pkg::ANGLE_FRACTION_BITS);
    r[0][0] = one - 2 * (dy * dy + dz * dz);
    r[0][1] = 2 * (dx * dy - dz * dw);
    r[0][2] = 2 * (dx * dz + dy * dw);
    r[1][0] = 2 * (dx * dy + dz * dw);
    r[1][1] = one - 2 * (dx * dx + dz * dz);
    r[1][2] = 2 * (dy * dz - dx * dw);
    r[2][0] = 2 * (dx * dz - dy * dw);
    r[2][1] = 2 * (dy * dz + dx * dw);
    r[2][2] = one - 2 * (dx * dx + dy * dy);
    // rotate by the transpose, mask, accumulate
    asat = 0;
    asum = 0;
    for (int i = 0; i < 3; i++) begin
      acc = r[0][i] * e[0] + r[1][i] * e[1] + r[2][i] * e[2];
      a = round_half_away(acc, 2 * pew_pkg::ANGLE_FRACTION_BITS);
      if (!axis_en[3 + i]) continue;
      m = (a < 0) ? -a : a;
      if (m > pew_pkg::ATT_MAX) begin
        asat = 1;
        continue;
      end
      asum += m * m;
    end
    aerr = int_sqrt(asum);
    if (asat || aerr > pew_pkg::ATT_MAX) begin
      asat = 1;
      aerr = pew_pkg::ATT_MAX;
    end
    aover = asat || asum > att_limit * att_limit;
    if (pover || aover) fault_q = 1;
    res.shutdown = fault_q;
    res.pos_err_norm = perr[pew_pkg::POS_W-1:0];
    res.att_err_norm = aerr[pew_pkg::ATT_W-1:0];
    return 1;
  endfunction

  // sender: hold the beat until taken, idle at random between beats
  always @(posedge clk) begin
    pose_error_t res;
    bit          take, offer;
    take = pose_in.valid && pose_in.ready;
    if (take) begin
      if (watch_pose(pending_items[0], res)) expected_errors.push_back(res);
      void'(pending_items.pop_front());
    end
    if (rst) begin
      pose_in.valid <= 1'b0;
    end else if (!pose_in.valid || take) begin
      offer = pending_items.size() > 0 && (calm || $urandom_range(99) >= idle_pct);
      pose_in.valid <= offer;
      if (pending_items.size() > 0) begin
        pose_in.kind              <= pending_items[0].kind;
        pose_in.frame_is_inertial <= pending_items[0].frame_is_inertial;
        pose_in.ignore_axes       <= pending_items[0].ignore_axes;
        pose_in.pos_x             <= pending_items[0].pos[0];
        pose_in.pos_y             <= pending_items[0].pos[1];
        pose_in.pos_z             <= pending_items[0].pos[2];
        pose_in.quat_w            <= pending_items[0].quat[0];
        pose_in.quat_x            <= pending_items[0].quat[1];
        pose_in.quat_y            <= pending_items[0].quat[2];
        pose_in.quat_z            <= pending_items[0].quat[3];
      end
    end
  end

  // receiver: compare each beat, one long hold-off after a while
  int results_seen;
  int stall_left;
  always @(posedge clk) begin
    pose_error_t want;
    if (err_out.valid && err_out.ready) begin
      results_seen++;
      if (results_seen == 40) stall_left = LONG_STALL;
      if (expected_errors.size() == 0) begin
        $error("unexpected result beat");
        failed = 1;
      end else begin
        want = expected_errors.pop_front();
        if (err_out.shutdown !== want.shutdown) begin
          $error("shutdown: expected %0d, got %0d", want.shutdown, err_out.shutdown);
          failed = 1;
        end
        if (err_out.pos_err_norm !== want.pos_err_norm) begin
          $error("pos_err_norm: expected %0d, got %0d", want.pos_err_norm,
                 err_out.pos_err_norm);
          failed = 1;
        end
        if (err_out.att_err_norm !== want.att_err_norm) begin
          $error("att_err_norm: expected %0d, got %0d", want.att_err_norm,
                 err_out.att_err_norm);
          failed = 1;
        end
      end
    end
    if (stall_left > 0) begin
      stall_left--;
      err_out.ready <= 1'b0;
    end else begin
      err_out.ready <= !rst && (calm || $urandom_range(99) >= idle_pct);
    end
  end

  // give up when nothing moves for too long
  int quiet_cycles;
  always @(posedge clk) begin
    if ((pose_in.valid && pose_in.ready) || (err_out.valid && err_out.ready) || rst) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic reg_write(logic idx, logic [31:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx == pew_pkg::REG_POS_LIMIT) pos_limit = val;
    else att_limit = val[pew_pkg::ATT_W-1:0];
  endtask

  task automatic drain();
    wait (pending_items.size() == 0 && expected_errors.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  function automatic pose_item_t make_item(logic kind, logic fr, logic [5:0] ign,
                                           longint px, longint py, longint pz,
                                           int qw, int qx, int qy, int qz);
    pose_item_t it;
    it.kind = kind; it.frame_is_inertial = fr; it.ignore_axes = ign;
    it.pos[0] = px; it.pos[1] = py; it.pos[2] = pz;
    it.quat[0] = qw; it.quat[1] = qx; it.quat[2] = qy; it.quat[3] = qz;
    return it;
  endfunction

  function automatic int rand_quat();
    if ($urandom_range(3) == 0) return $urandom_range(32768) - 16384;
    return $urandom_range(4000) - 2000;
  endfunction

  function automatic longint rand_pos();
    case ($urandom_range(3))
      0: return $signed($urandom());
      1: return $urandom_range(1 << 20) - (1 << 19);
      default: return $urandom_range(40000) - 20000;
    endcase
  endfunction

  function automatic pose_item_t rand_item();
    pose_item_t it;
    logic [5:0] ign;
    ign = ($urandom_range(2) == 0) ? 6'($urandom()) : 6'd0;
    it = make_item(($urandom_range(3) != 0) ? pew_pkg::KIND_POSE : pew_pkg::KIND_SETPOINT,
                   $urandom_range(9) != 0, ign, rand_pos(), rand_pos(), rand_pos(),
                   ($urandom_range(4) == 0) ? rand_quat() : 16384 - $urandom_range(3000),
                   rand_quat(), rand_quat(), rand_quat());
    if (it.kind == pew_pkg::KIND_POSE && $urandom_range(9) == 0) begin
      it.frame_is_inertial = 1'($urandom_range(1));
      it.ignore_axes = 6'($urandom());
    end
    return it;
  endfunction

  initial begin
    logic [31:0] pos_lims [4];
    logic [14:0] att_lims [4];
    rst = 1'b1;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    pose_in.valid = 0; pose_in.kind = 0; pose_in.frame_is_inertial = 0;
    pose_in.ignore_axes = '0; pose_in.pos_x = '0; pose_in.pos_y = '0; pose_in.pos_z = '0;
    pose_in.quat_w = '0; pose_in.quat_x = '0; pose_in.quat_y = '0; pose_in.quat_z = '0;
    err_out.ready = 0;
    failed = 0; calm = 0; idle_pct = 14;
    results_seen = 0; stall_left = 0; quiet_cycles = 0;
    sp_seen = 0; pose_seen_q = 0; fault_q = 0;
    tgt_pos = '{0, 0, 0};
    tgt_quat = '{pew_pkg::QUAT_ONE, 0, 0, 0};
    axis_en = '1;
    pos_limit = pew_pkg::POS_LIMIT_RESET;
    att_limit = pew_pkg::ATT_LIMIT_RESET;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    reg_write(pew_pkg::REG_POS_LIMIT, 32'hFFFF_FFFF);
    reg_write(pew_pkg::REG_ATT_LIMIT, 32'h7FFF);

    // directed: drop rules, masks, sign flip, extremes
    pending_items.push_back(make_item(pew_pkg::KIND_POSE, 1, 0, 5, 5, 5, 16384, 0, 0, 0));
    pending_items.push_back(make_item(pew_pkg::KIND_SETPOINT, 0, 0, 9, 9, 9,
                                      16384, 0, 0, 0));
    pending_items.push_back(make_item(pew_pkg::KIND_SETPOINT, 1, 0, 100, 0, 0,
                                      0, 16384, 0, 0));
    pending_items.push_back(make_item(pew_pkg::KIND_POSE, 1, 0, 7, 7, 7, 16384, 0, 0, 0));
    pending_items.push_back(make_item(pew_pkg::KIND_POSE, 0, 63, 0, 0, 0, 16384, 0, 0, 0));
    pending_items.push_back(make_item(pew_pkg::KIND_POSE, 1, 0, 65536, -65536, 3,
                                      16000, 300, -200, 90));
    pending_items.push_back(make_item(pew_pkg::KIND_POSE, 1, 0, 0, 0, 0, -16384, 0, 0, 0));
    pending_items.push_back(make_item(pew_pkg::KIND_SETPOINT, 1, 0, 1000, -2000, 3000,
                                      11585, 0, 11585, 0));
    pending_items.push_back(make_item(pew_pkg::KIND_POSE, 1, 0, 1000, -2000, 3000,
                                      11585, 0, 11585, 0));
    pending_items.push_back(make_item(pew_pkg::KIND_POSE, 1, 0, 900, -1900, 3100,
                                      -11585, 0, -11000, 500));
    pending_items.push_back(make_item(pew_pkg::KIND_POSE, 1, 0, 0, 0, 0, 0, 16384, 0, 0));
    pending_items.push_back(make_item(pew_pkg::KIND_SETPOINT, 1, 6'b010101, 0, 0, 0,
                                      16384, 16384, -16384, 16384));
    pending_items.push_back(make_item(pew_pkg::KIND_POSE, 1, 0, 2000, 3000, 4000,
                                      -16384, 16384, 16384, -16384));
    pending_items.push_back(make_item(pew_pkg::KIND_SETPOINT, 1, 63, 0, 0, 0,
                                      16384, 0, 0, 0));
    pending_items.push_back(make_item(pew_pkg::KIND_POSE, 1, 0, -2147483648, 2147483647, 0,
                                      -16384, -16384, -16384, -16384));
    pending_items.push_back(make_item(pew_pkg::KIND_SETPOINT, 1, 6'b111000, 2147483647,
                                      2147483647, 2147483647, -16384, 16384, 16384, 16384));
    pending_items.push_back(make_item(pew_pkg::KIND_POSE, 1, 0, -2147483648, -2147483648,
                                      -2147483648, 0, 0, 0, 0));
    pending_items.push_back(make_item(pew_pkg::KIND_SETPOINT, 1, 6'b000111, -2147483648, 0,
                                      2147483647, 16384, -16384, 0, 16384));
    pending_items.push_back(make_item(pew_pkg::KIND_POSE, 1, 0, 2147483647, 0, -2147483648,
                                      -16384, 16384, -16384, 0));
    pending_items.push_back(make_item(pew_pkg::KIND_SETPOINT, 1, 0, 0, 0, 0,
                                      16384, 0, 0, 0));
    pending_items.push_back(make_item(pew_pkg::KIND_POSE, 1, 0, 2, 2, 2, 16384, 2, 2, 2));
    drain();

    // random phases, each with its own limits; one phase runs without gaps
    pos_lims = '{32'd0, pew_pkg::POS_LIMIT_RESET, 32'h0004_0000, 32'hFFFF_FFFF};
    att_lims = '{15'd0, pew_pkg::ATT_LIMIT_RESET, 15'd8000, 15'h7FFF};
    for (int ph = 0; ph < 4; ph++) begin
      reg_write(pew_pkg::REG_POS_LIMIT, pos_lims[ph]);
      reg_write(pew_pkg::REG_ATT_LIMIT, 32'(att_lims[ph]));
      calm = (ph == 2);
      repeat (300) pending_items.push_back(rand_item());
      drain();
    end

    if (!failed) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

@@ pose_error_watchdog.f @@
rtl/pew_pkg.sv
rtl/pew_if.sv
rtl/pose_error_watchdog.sv
bench/pose_error_watchdog_tb.sv
